// ===== hw/rtl/spp_pkg.sv =====
// Shared types, constants and the header table for the SPP data frame parser.
package spp_pkg;

	localparam int unsigned HDR_LEN = 12;
	localparam int unsigned MC_W = 4;
	localparam int unsigned LEN_W = 16;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;
	localparam logic [MC_W-1:0] HDR_LAST_IDX = 4'd11;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_ID      = 3'd1,
		PH_SKIP    = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	// one result item as it leaves the parser
	typedef struct packed {
		logic       valid;
		logic [7:0] payload_byte;
		logic [7:0] link_id;
		logic       frame_last;
	} spp_res_t;

	// header text "+BTSPPDATA: "; hit is low past the end of the text
	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} hdr_char_t;

	function automatic hdr_char_t hdr_char(input logic [MC_W-1:0] idx);
		hdr_char_t r;
		r.hit = 1'b1;
		case (idx)
			4'd0:  r.ch = 8'h2B; // '+'
			4'd1:  r.ch = 8'h42; // 'B'
			4'd2:  r.ch = 8'h54; // 'T'
			4'd3:  r.ch = 8'h53; // 'S'
			4'd4:  r.ch = 8'h50; // 'P'
			4'd5:  r.ch = 8'h50; // 'P'
			4'd6:  r.ch = 8'h44; // 'D'
			4'd7:  r.ch = 8'h41; // 'A'
			4'd8:  r.ch = 8'h54; // 'T'
			4'd9:  r.ch = 8'h41; // 'A'
			4'd10: r.ch = 8'h3A; // ':'
			4'd11: r.ch = 8'h20; // ' '
			default: begin
				r.hit = 1'b0;
				r.ch = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/spp_parse.sv =====
// Parser state machine: header hunt, id capture, length build-up and payload count.
module spp_parse (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [7:0]                   rx_byte,
	input  logic [spp_pkg::LEN_W-1:0]    max_len,
	output spp_pkg::spp_res_t            res
);

	spp_pkg::phase_t               phase_q, phase_d;
	logic [spp_pkg::MC_W-1:0]      match_q, match_d;
	logic [7:0]                    id_q, id_d;
	logic [spp_pkg::LEN_W-1:0]     rem_q, rem_d;
	spp_pkg::hdr_char_t            hc;
	logic                          last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= spp_pkg::PH_HUNT;
			match_q <= '0;
			id_q <= '0;
			rem_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			match_q <= match_d;
			id_q <= id_d;
			rem_q <= rem_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		match_d = match_q;
		id_d = id_q;
		rem_d = rem_q;
		hc = spp_pkg::hdr_char(match_q);
		last = (rem_q <= spp_pkg::LEN_W'(1));
		res.valid = 1'b0;
		res.payload_byte = rx_byte;
		res.link_id = id_q;
		res.frame_last = last;
		case (phase_q)
			spp_pkg::PH_HUNT: begin
				if (!hc.hit || hc.ch != rx_byte) begin
					match_d = '0;
				end else if (match_q == spp_pkg::HDR_LAST_IDX) begin
					match_d = '0;
					phase_d = spp_pkg::PH_ID;
				end else begin
					match_d = match_q + spp_pkg::MC_W'(1);
				end
			end
			spp_pkg::PH_ID: begin
				id_d = rx_byte;
				phase_d = spp_pkg::PH_SKIP;
			end
			spp_pkg::PH_SKIP: begin
				phase_d = spp_pkg::PH_LEN;
				match_d = '0;
				rem_d = '0;
			end
			spp_pkg::PH_LEN: begin
				if (rx_byte != spp_pkg::CHAR_COMMA) begin
					// rem*10 + byte - '0', wrapping at 16 bits
					rem_d = (rem_q << 3) + (rem_q << 1) + spp_pkg::LEN_W'(rx_byte)
						- spp_pkg::LEN_W'(spp_pkg::CHAR_ZERO);
				end else if (rem_q >= max_len || rem_q == '0) begin
					phase_d = spp_pkg::PH_HUNT;
					match_d = '0;
				end else begin
					phase_d = spp_pkg::PH_PAYLOAD;
				end
			end
			spp_pkg::PH_PAYLOAD: begin
				res.valid = 1'b1;
				rem_d = rem_q - spp_pkg::LEN_W'(1);
				if (last) begin
					rem_d = '0;
					phase_d = spp_pkg::PH_HUNT;
					match_d = '0;
				end
			end
			default: begin
				phase_d = spp_pkg::PH_HUNT;
				match_d = '0;
			end
		endcase
	end

	// header index never runs past the last header character
	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		match_q <= spp_pkg::HDR_LAST_IDX)
		else $error("header match index out of range");

	// a payload phase always has at least one byte still due
	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == spp_pkg::PH_PAYLOAD |-> rem_q != '0)
		else $error("payload phase with zero length");

	// the last byte of a frame sends the parser back to the hunt
	a_last_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid && res.frame_last |=>
			phase_q == spp_pkg::PH_HUNT && match_q == '0)
		else $error("parser not hunting after last payload byte");

endmodule

// ===== hw/rtl/spp_data_frame_parser.sv =====
// Top level of the SPP data frame parser: input register, parser and result register.
//
// Byte-stream parser for modem data frames of the form "+BTSPPDATA: <id>?<len>,<payload>".
// Each item on the s_ side is one received serial byte. The parser hunts for the twelve
// byte header, keeps the following byte as the link id, skips one byte, then builds a
// decimal length (any non-comma byte adds byte-'0', wrapping at 16 bits) up to a comma.
// A length of zero, or one at or above max_payload_length, drops the frame and the hunt
// restarts. Otherwise the next <len> bytes each leave on the m_ side as one item carrying
// the byte and the link id, with m_tlast on the final one. Header, id, skip and length
// bytes produce no item. Throughput is one byte per clock while m_tready does not stall the
// result register: a byte is registered on entry, goes through the parser's combinational
// next-state logic and, when it yields an item, is registered in the result register,
// which drives m_tvalid.
// The input stage moves on whenever the result register is empty or being drained,
// so s_tready only drops while a result sits unaccepted and another byte is waiting.
// max_payload_length resets to 1024 and should only be written while the block is idle.
module spp_data_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        max_payload_length_we,
	input  logic [15:0] max_payload_length_wdata,
	// byte input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// payload output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] payload_byte, [15:8] link_id
	output logic        m_tlast    // frame_last
);

	logic [spp_pkg::LEN_W-1:0] max_len_q;
	logic                      v_s1;
	logic [7:0]                byte_s1;
	logic                      out_free;
	logic                      advance;
	spp_pkg::spp_res_t         res;
	logic [7:0]                pay_s2;
	logic [7:0]                id_s2;
	logic                      last_s2;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= spp_pkg::MAX_LEN_RESET;
		end else if (max_payload_length_we) begin
			max_len_q <= max_payload_length_wdata;
		end
	end

	// stage 1 moves into the parser when the result register can take its outcome
	assign out_free = !m_tvalid || m_tready;
	assign advance = v_s1 && out_free;
	assign s_tready = !v_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	spp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.max_len (max_len_q),
		.res     (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			pay_s2 <= res.payload_byte;
			id_s2 <= res.link_id;
			last_s2 <= res.frame_last;
		end
	end

	assign m_tdata = {id_s2, pay_s2};
	assign m_tlast = last_s2;

endmodule

// ===== tb/sv/tb_spp_data_frame_parser.sv =====
// Self-checking testbench for spp_data_frame_parser: directed frames, then random byte traffic.
`timescale 1ns / 100ps

module tb_spp_data_frame_parser;

	// one payload item as it should leave the parser
	typedef struct {
		logic [7:0] payload_byte;
		logic [7:0] link_id;
		logic       frame_last;
	} payload_item_t;

	logic        clk;
	logic        arst_n;
	logic        max_payload_length_we;
	logic [15:0] max_payload_length_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] payload_byte, [15:8] link_id
	logic        m_tlast;   // frame_last

	// parser mirror: its own copy of the state and the length limit
	spp_pkg::phase_t           ph;
	logic [spp_pkg::MC_W-1:0]  hdr_pos;
	logic [7:0]                link_id_held;
	logic [spp_pkg::LEN_W-1:0] len_left;
	logic [spp_pkg::LEN_W-1:0] max_len;

	payload_item_t payload_due_q[$];   // payload items still owed by the block

	string hdr_text = "+BTSPPDATA: ";
	int    fail_count = 0;
	int    bytes_sent = 0;
	bit    idle_en = 1'b1;               // random gaps on both sides
	int    ready_hold = 0;

	spp_data_frame_parser u_dut (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.max_payload_length_we    (max_payload_length_we),
		.max_payload_length_wdata (max_payload_length_wdata),
		.s_tvalid                 (s_tvalid),
		.s_tready                 (s_tready),
		.s_tdata                  (s_tdata),
		.m_tvalid                 (m_tvalid),
		.m_tready                 (m_tready),
		.m_tdata                  (m_tdata),
		.m_tlast                  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ---------------------------------------------------------------
	// Parser mirror: advance on one accepted byte, queue any payload item
	// ---------------------------------------------------------------
	function automatic void go_hunting();
		ph = spp_pkg::PH_HUNT;
		hdr_pos = '0;
	endfunction

	function automatic void parse_rx_byte(input logic [7:0] b);
		payload_item_t it;
		logic          last;
		case (ph)
			spp_pkg::PH_HUNT: begin
				// a mismatching byte is dropped, not retried as the first header char
				if (hdr_pos >= spp_pkg::HDR_LEN || hdr_text[hdr_pos] != b) begin
					hdr_pos = '0;
				end else if (hdr_pos == spp_pkg::HDR_LAST_IDX) begin
					hdr_pos = '0;
					ph = spp_pkg::PH_ID;
				end else begin
					hdr_pos = hdr_pos + 1'b1;
				end
			end
			spp_pkg::PH_ID: begin
				link_id_held = b;
				ph = spp_pkg::PH_SKIP;
			end
			spp_pkg::PH_SKIP: begin
				ph = spp_pkg::PH_LEN;
				hdr_pos = '0;
				len_left = '0;
			end
			spp_pkg::PH_LEN: begin
				// any non-comma counts as a digit, byte - '0', wrapping at 16 bits
				if (b != spp_pkg::CHAR_COMMA) begin
					len_left = len_left * 16'd10 + {8'h00, b}
						- {8'h00, spp_pkg::CHAR_ZERO};
				end else if (len_left >= max_len || len_left == '0) begin
					go_hunting();
				end else begin
					ph = spp_pkg::PH_PAYLOAD;
				end
			end
			spp_pkg::PH_PAYLOAD: begin
				last = (len_left <= 16'd1);
				it.payload_byte = b;
				it.link_id = link_id_held;
				it.frame_last = last;
				payload_due_q.push_back(it);
				len_left = len_left - 1'b1;
				if (last) begin
					len_left = '0;
					go_hunting();
				end
			end
			default: go_hunting();
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Byte sender: optional gap, then hold the item until it is taken
	// ---------------------------------------------------------------
	task automatic push_rx_byte(input logic [7:0] b);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		parse_rx_byte(b);
		bytes_sent++;
	endtask

	// header, id, skip byte, length text, comma, then n_pay random bytes
	task automatic send_frame(input logic [7:0] id, input string len_txt, input int n_pay);
		for (int i = 0; i < spp_pkg::HDR_LEN; i++) push_rx_byte(hdr_text[i]);
		push_rx_byte(id);
		push_rx_byte(8'($urandom_range(0, 255)));
		for (int i = 0; i < len_txt.len(); i++) push_rx_byte(len_txt[i]);
		push_rx_byte(spp_pkg::CHAR_COMMA);
		repeat (n_pay) push_rx_byte(8'($urandom_range(0, 255)));
	endtask

	// stop sending and let every owed item and the pipeline drain
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (payload_due_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [15:0] v);
		settle_idle();
		max_payload_length_we <= 1'b1;
		max_payload_length_wdata <= v;
		@(posedge clk);
		max_payload_length_we <= 1'b0;
		max_len = v;
	endtask

	// one random unit of traffic: mostly frames, some noise and broken ones
	task automatic send_random_unit();
		int unsigned sel;
		int unsigned n;
		int unsigned lim;
		int unsigned k;
		logic [7:0]  ch;
		string       txt;
		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			lim = (max_len > 16'd25) ? 24 : int'(max_len) - 1;
			case ($urandom_range(0, 19))
				0: n = 0;
				1: n = int'(max_len) + $urandom_range(0, 4);   // at or over the limit
				default: n = $urandom_range(1, lim);
			endcase
			send_frame(8'($urandom_range(0, 255)), $sformatf("%0d", n),
				(n > 40) ? $urandom_range(0, 8) : n);
		end else if (sel < 80) begin
			// junk in the length field; zero bytes cannot sit in a string
			txt = "";
			repeat ($urandom_range(1, 3)) begin
				ch = 8'($urandom_range(1, 255));
				if (ch == spp_pkg::CHAR_COMMA) ch = "7";
				txt = {txt, $sformatf("%c", ch)};
			end
			send_frame(8'($urandom_range(0, 255)), txt, $urandom_range(0, 10));
		end else if (sel < 90) begin
			k = $urandom_range(1, spp_pkg::HDR_LEN - 1);
			for (int i = 0; i < k; i++) push_rx_byte(hdr_text[i]);
			push_rx_byte(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 6)) push_rx_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: random stall bursts and the field-by-field check
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		payload_item_t exp_item;
		if (m_tvalid && m_tready) begin
			if (payload_due_q.size() == 0) begin
				$error("payload item with none owed: byte %02h link %02h last %0b",
					m_tdata[7:0], m_tdata[15:8], m_tlast);
				fail_count++;
			end else begin
				exp_item = payload_due_q.pop_front();
				if (m_tdata[7:0] !== exp_item.payload_byte) begin
					$error("payload_byte: expected %02h, got %02h",
						exp_item.payload_byte, m_tdata[7:0]);
					fail_count++;
				end
				if (m_tdata[15:8] !== exp_item.link_id) begin
					$error("link_id: expected %02h, got %02h", exp_item.link_id, m_tdata[15:8]);
					fail_count++;
				end
				if (m_tlast !== exp_item.frame_last) begin
					$error("frame_last: expected %0b, got %0b", exp_item.frame_last, m_tlast);
					fail_count++;
				end
			end
		end
		if (ready_hold != 0)
			ready_hold = ready_hold - 1;
		else if (idle_en && $urandom_range(0, 5) == 0)
			ready_hold = $urandom_range(1, 3);
		m_tready <= (ready_hold == 0);
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset limit of 1024: short frames, a single-byte frame, zero and limit lengths
	task automatic test_default_limit();
		send_frame(8'h00, "3", 3);
		send_frame(8'hFF, "1", 1);
		send_frame(8'h35, "0", 2);      // zero length goes back to hunting
		send_frame(8'h41, "1024", 3);   // exactly the limit: dropped
		send_frame(8'h80, "25", 25);    // two-digit length, full frame
	endtask

	// broken headers: the mismatching byte is not taken as a fresh start
	task automatic test_header_mismatch();
		push_rx_byte("+");
		push_rx_byte("B");
		send_frame(8'h12, "2", 2);      // "+B+BTSPPDATA: " never locks on
		for (int i = 0; i < spp_pkg::HDR_LEN - 1; i++) push_rx_byte(hdr_text[i]);
		push_rx_byte("+");
		send_frame(8'h7E, "2", 2);
	endtask

	// non-digits in the length and 16-bit wrap of the sum
	task automatic test_length_quirks();
		send_frame(8'h01, "1A", 27);    // 1*10 + ('A' - '0') = 27
		send_frame(8'h02, "#", 4);      // below '0': wraps far over the limit
		send_frame(8'h03, "65537", 1);  // wraps to 1
		send_frame(8'h04, "000", 2);
	endtask

	// extreme settings of the length limit
	task automatic test_limit_extremes();
		write_max_len(16'd1);           // every frame dropped
		send_frame(8'h10, "1", 1);
		send_frame(8'h11, "2", 2);
		write_max_len(16'd65535);
		send_frame(8'h20, "65535", 2);  // at the limit
		send_frame(8'h21, "65536", 2);  // wraps to zero
		send_frame(8'h22, "00007", 7);
		write_max_len(16'd2);
		send_frame(8'h23, "1", 1);
		send_frame(8'h24, "2", 2);
	endtask

	// random traffic in chunks, each under its own limit, draining between
	task automatic test_random_traffic();
		int start;
		for (int chunk = 0; chunk < 3; chunk++) begin
			case ($urandom_range(0, 5))
				0: write_max_len(16'd1);
				1: write_max_len(16'd65535);
				2: write_max_len(spp_pkg::MAX_LEN_RESET);
				default: write_max_len(16'($urandom_range(2, 40)));
			endcase
			start = bytes_sent;
			while (bytes_sent - start < 110) begin
				send_random_unit();
				if ($urandom_range(0, 39) == 0) settle_idle();
			end
		end
	endtask

	// last stretch: back-to-back bytes, receiver always ready
	task automatic test_steady_stream();
		int start;
		write_max_len(16'($urandom_range(8, 30)));
		idle_en = 1'b0;
		start = bytes_sent;
		while (bytes_sent - start < 170) send_random_unit();
	endtask

	initial begin
		ph = spp_pkg::PH_HUNT;
		hdr_pos = '0;
		link_id_held = '0;
		len_left = '0;
		max_len = spp_pkg::MAX_LEN_RESET;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		max_payload_length_we <= 1'b0;
		max_payload_length_wdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_limit();
		test_header_mismatch();
		test_length_quirks();
		test_limit_extremes();
		test_random_traffic();
		test_steady_stream();

		s_tvalid <= 1'b0;
		while (payload_due_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("spp_data_frame_parser: match");
		else
			$display("spp_data_frame_parser: mismatch");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("spp_data_frame_parser: mismatch");
		$finish;
	end

endmodule
